// ===== design/sfd_pkg.sv =====
// Shared types, constants and the channel length table for the scoreboard
// serial frame decoder. No dependencies.
`timescale 1ns / 1ps

package sfd_pkg;

   localparam int CHANNEL_COUNT      = 32;
   localparam int DIGITS_PER_CHANNEL = 16;
   localparam int MAX_FRAME_BYTES    = 10;

   localparam int BYTE_W  = 8;
   localparam int CH_W    = $clog2(CHANNEL_COUNT);
   localparam int IDX_W   = $clog2(DIGITS_PER_CHANNEL);
   localparam int NIB_W   = 4;
   localparam int COUNT_W = $clog2(MAX_FRAME_BYTES + 1);
   localparam int PTR_W   = $clog2(MAX_FRAME_BYTES);
   localparam int PERIOD_W = 8;

   localparam logic [NIB_W-1:0]    BLANK_NIBBLE     = 4'hF;
   localparam logic [PERIOD_W-1:0] RUN_PERIOD_RESET = 8'd6;

   // channel-zero digits watched for the running test: indexes 6, 8, 10, 12,
   // i.e. digit numbers 3..6 with half-select low
   localparam int RUN_SLOTS      = 4;
   localparam int RUN_SLOT_W     = 2;
   localparam logic [IDX_W-2:0] RUN_FIRST_DIGIT = 3'd3;
   localparam logic [IDX_W-2:0] RUN_LAST_DIGIT  = 3'd6;

   // job queue between front and back
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_DIGIT   = 2'd0,
      KIND_START   = 2'd1,
      KIND_STOP    = 2'd2,
      KIND_OVERRUN = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic [CH_W-1:0]    channel;
      logic [IDX_W-1:0]   digit_index;
      logic [NIB_W-1:0]   digit_value;
      logic               last;
   } result_type;

   // run_check marks the final digit of a channel-zero frame
   typedef struct packed {
      result_type res;
      logic       run_check;
   } job_type;

   localparam logic [COUNT_W-1:0] CHAN_LEN_TABLE [CHANNEL_COUNT] = '{
      COUNT_W'(7), COUNT_W'(9), COUNT_W'(9), COUNT_W'(9),
      COUNT_W'(9), COUNT_W'(9), COUNT_W'(9), COUNT_W'(9),
      COUNT_W'(9), COUNT_W'(9), COUNT_W'(9), COUNT_W'(0),
      COUNT_W'(9), COUNT_W'(0), COUNT_W'(9), COUNT_W'(9),
      COUNT_W'(0), COUNT_W'(9), COUNT_W'(9), COUNT_W'(0),
      COUNT_W'(0), COUNT_W'(0), COUNT_W'(5), COUNT_W'(0),
      COUNT_W'(0), COUNT_W'(0), COUNT_W'(0), COUNT_W'(0),
      COUNT_W'(0), COUNT_W'(0), COUNT_W'(0), COUNT_W'(0)
   };

   // expected frame length in bytes, address word included; 0 = unused
   function automatic logic [COUNT_W-1:0] chan_len(input logic [CH_W-1:0] ch);
      return CHAN_LEN_TABLE[ch];
   endfunction

endpackage

// ===== design/sfd_front.sv =====
// Front end: accepts serial bytes, buffers the open frame and turns a closed
// frame into digit jobs, one per cycle unless job_full. Depends on sfd_pkg.
`timescale 1ns / 1ps

module sfd_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   output logic                     req_full,
   input  logic [sfd_pkg::BYTE_W-1:0] req_rx_byte,
   output logic                     job_push,
   output sfd_pkg::job_type         job_data,
   input  logic                     job_full
);
   import sfd_pkg::*;

   typedef enum logic {
      ST_ACCEPT,
      ST_DRAIN
   } state_type;

   state_type            state_ff, state_in;
   logic                 frame_open_ff, frame_open_in;
   logic [COUNT_W-1:0]   byte_count_ff, byte_count_in;
   logic [CH_W-1:0]      frame_channel_ff, frame_channel_in;
   logic                 half_select_ff, half_select_in;
   logic [CH_W-1:0]      drain_channel_ff, drain_channel_in;
   logic                 drain_half_ff, drain_half_in;
   logic [COUNT_W-1:0]   drain_len_ff, drain_len_in;
   logic [COUNT_W-1:0]   drain_pos_ff, drain_pos_in;
   logic [BYTE_W-1:0]    buffer_ff [MAX_FRAME_BYTES];

   logic                 accept;
   logic                 is_addr;
   logic                 frame_match;
   logic                 overrun;
   logic                 drain_final;
   logic [BYTE_W-1:0]    drain_byte;
   logic [COUNT_W-1:0]   frame_len;

   assign req_full = (state_ff == ST_DRAIN) || job_full;
   assign accept   = req_push && !req_full;
   assign is_addr  = req_rx_byte[BYTE_W-1];

   assign frame_len   = chan_len(frame_channel_ff);
   assign frame_match = frame_open_ff && (byte_count_ff == frame_len);
   // a data beat that makes the count reach the limit closes the frame
   assign overrun     = accept && !is_addr && frame_open_ff &&
                        (byte_count_ff == COUNT_W'(MAX_FRAME_BYTES - 1));

   assign drain_byte  = buffer_ff[drain_pos_ff[PTR_W-1:0]];
   assign drain_final = (drain_pos_ff + COUNT_W'(1)) == drain_len_ff;

   // job toward the back end
   always_comb begin
      job_push = 1'b0;
      job_data = '0;
      if (state_ff == ST_DRAIN) begin
         job_push                   = !job_full;
         job_data.res.kind          = KIND_DIGIT;
         job_data.res.channel       = drain_channel_ff;
         job_data.res.digit_index   = {drain_byte[6:4], drain_half_ff};
         job_data.res.digit_value   = ~drain_byte[NIB_W-1:0];
         job_data.res.last          = drain_final && (drain_channel_ff != '0);
         job_data.run_check         = drain_final && (drain_channel_ff == '0);
      end else if (overrun) begin
         job_push                   = 1'b1;
         job_data.res.kind          = KIND_OVERRUN;
         job_data.res.channel       = frame_channel_ff;
         job_data.res.last          = 1'b1;
         job_data.run_check         = 1'b0;
      end
   end

   // next state
   always_comb begin
      state_in         = state_ff;
      frame_open_in    = frame_open_ff;
      byte_count_in    = byte_count_ff;
      frame_channel_in = frame_channel_ff;
      half_select_in   = half_select_ff;
      drain_channel_in = drain_channel_ff;
      drain_half_in    = drain_half_ff;
      drain_len_in     = drain_len_ff;
      drain_pos_in     = drain_pos_ff;
      case (state_ff)
         ST_ACCEPT: begin
            if (accept && is_addr) begin
               if (frame_match) begin
                  state_in         = ST_DRAIN;
                  drain_channel_in = frame_channel_ff;
                  drain_half_in    = half_select_ff;
                  drain_len_in     = frame_len;
                  drain_pos_in     = COUNT_W'(1);
               end
               frame_open_in    = 1'b1;
               byte_count_in    = COUNT_W'(1);
               half_select_in   = req_rx_byte[0];
               frame_channel_in = ~req_rx_byte[CH_W:1];
            end else if (accept && frame_open_ff) begin
               byte_count_in = byte_count_ff + COUNT_W'(1);
               if (overrun) begin
                  frame_open_in = 1'b0;
               end
            end
         end
         ST_DRAIN: begin
            if (!job_full) begin
               drain_pos_in = drain_pos_ff + COUNT_W'(1);
               if (drain_final) begin
                  state_in = ST_ACCEPT;
               end
            end
         end
         default: begin
            state_in = ST_ACCEPT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_ACCEPT;
         frame_open_ff    <= 1'b0;
         byte_count_ff    <= '0;
         frame_channel_ff <= '0;
         half_select_ff   <= 1'b0;
         drain_channel_ff <= '0;
         drain_half_ff    <= 1'b0;
         drain_len_ff     <= '0;
         drain_pos_ff     <= '0;
      end else begin
         state_ff         <= state_in;
         frame_open_ff    <= frame_open_in;
         byte_count_ff    <= byte_count_in;
         frame_channel_ff <= frame_channel_in;
         half_select_ff   <= half_select_in;
         drain_channel_ff <= drain_channel_in;
         drain_half_ff    <= drain_half_in;
         drain_len_ff     <= drain_len_in;
         drain_pos_ff     <= drain_pos_in;
      end
   end

   // frame buffer: address word at entry 0, data beats after it
   always_ff @(posedge clock) begin
      if (accept && is_addr) begin
         buffer_ff[0] <= req_rx_byte;
      end else if (accept && frame_open_ff &&
                   (byte_count_ff < COUNT_W'(MAX_FRAME_BYTES))) begin
         buffer_ff[byte_count_ff[PTR_W-1:0]] <= req_rx_byte;
      end
   end

endmodule

// ===== design/sfd_job_fifo.sv =====
// Short job queue that decouples the front end from the back end.
// Depends on sfd_pkg.
`timescale 1ns / 1ps

module sfd_job_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sfd_pkg::job_type push_data,
   output logic             full,
   input  logic             pop,
   output sfd_pkg::job_type pop_data,
   output logic             empty
);
   import sfd_pkg::*;

   job_type                 mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   count_ff, count_in;
   logic                    do_push;
   logic                    do_pop;

   assign full     = count_ff == FIFO_CNT_W'(FIFO_DEPTH);
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + FIFO_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + FIFO_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + FIFO_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - FIFO_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/sfd_back.sv =====
// Back end: carries out jobs, keeps the channel-zero running digits, runs the
// periodic running check and drives the result register. Depends on sfd_pkg.
`timescale 1ns / 1ps

module sfd_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [sfd_pkg::PERIOD_W-1:0] csr_wr_data,
   input  sfd_pkg::job_type             job_data,
   input  logic                         job_empty,
   output logic                         job_pop,
   output sfd_pkg::result_type          rsp_data,
   output logic                         rsp_empty,
   input  logic                         rsp_pop
);
   import sfd_pkg::*;

   logic [PERIOD_W-1:0]   period_ff;
   logic [NIB_W-1:0]      run_digit_ff [RUN_SLOTS];
   logic [NIB_W-1:0]      run_digit_in [RUN_SLOTS];
   logic [PERIOD_W-1:0]   check_count_ff, check_count_in;
   logic                  pending_ff, pending_in;
   logic                  previous_ff;
   logic                  tail_ff;
   kind_type              tail_kind_ff;
   logic                  out_valid_ff;
   result_type            out_ff;

   logic                  out_free;
   logic                  slot_hit;
   logic [RUN_SLOT_W-1:0] slot;
   logic [IDX_W-2:0]      digit_no;
   logic                  running;
   logic [PERIOD_W-1:0]   count_inc;
   logic                  change;

   assign out_free  = !out_valid_ff || rsp_pop;
   assign job_pop   = out_free && !tail_ff && !job_empty;
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   // store update for a watched channel-zero digit
   assign digit_no = job_data.res.digit_index[IDX_W-1:1];
   assign slot_hit = (job_data.res.kind == KIND_DIGIT) && (job_data.res.channel == '0) &&
                     !job_data.res.digit_index[0] &&
                     (digit_no >= RUN_FIRST_DIGIT) && (digit_no <= RUN_LAST_DIGIT);
   assign slot     = RUN_SLOT_W'(digit_no - RUN_FIRST_DIGIT);

   always_comb begin
      for (int k = 0; k < RUN_SLOTS; k++) begin
         run_digit_in[k] = run_digit_ff[k];
      end
      if (job_pop && slot_hit) begin
         run_digit_in[slot] = job_data.res.digit_value;
      end
   end

   // running test on the store as it stands after this job
   always_comb begin
      running = 1'b0;
      for (int k = 0; k < RUN_SLOTS; k++) begin
         if ((run_digit_in[k] != BLANK_NIBBLE) && (run_digit_in[k] != '0)) begin
            running = 1'b1;
         end
      end
   end

   // periodic evaluation on the last digit of a channel-zero frame
   always_comb begin
      count_inc      = check_count_ff + PERIOD_W'(1);
      check_count_in = count_inc;
      pending_in     = pending_ff;
      if (count_inc >= period_ff) begin
         check_count_in = '0;
         pending_in     = running;
      end
   end
   assign change = pending_in != previous_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff      <= RUN_PERIOD_RESET;
         check_count_ff <= '0;
         pending_ff     <= 1'b0;
         previous_ff    <= 1'b0;
         tail_ff        <= 1'b0;
         out_valid_ff   <= 1'b0;
         for (int k = 0; k < RUN_SLOTS; k++) begin
            run_digit_ff[k] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            period_ff <= csr_wr_data;
         end
         for (int k = 0; k < RUN_SLOTS; k++) begin
            run_digit_ff[k] <= run_digit_in[k];
         end
         if (job_pop) begin
            out_valid_ff <= 1'b1;
            if (job_data.run_check) begin
               check_count_ff <= check_count_in;
               pending_ff     <= pending_in;
               previous_ff    <= pending_in;
               tail_ff        <= change;
            end
         end else if (out_free && tail_ff) begin
            out_valid_ff <= 1'b1;
            tail_ff      <= 1'b0;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (job_pop) begin
         out_ff <= job_data.res;
         if (job_data.run_check) begin
            out_ff.last  <= !change;
            tail_kind_ff <= pending_in ? KIND_START : KIND_STOP;
         end
      end else if (out_free && tail_ff) begin
         out_ff      <= '0;
         out_ff.kind <= tail_kind_ff;
         out_ff.last <= 1'b1;
      end
   end

endmodule

// ===== design/scoreboard_serial_frame_decoder.sv =====
// Scoreboard serial frame decoder, top level: front end, job queue, back end.
// An overrun beat goes via the job queue to the result register; the first
// digit of a frame closed by an address word passes the drain state first.
// Throughput: one data beat per cycle while req_full is low; an address word
// closing a valid frame holds req_full while the front end walks the buffer.
// Back end gives one result per cycle if popped, plus one for a start or stop.
// Reset is synchronous and clears all control state at once; no clearing pass.
`timescale 1ns / 1ps

module scoreboard_serial_frame_decoder (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic [sfd_pkg::BYTE_W-1:0]      req_rx_byte,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [1:0]                      rsp_kind,
   output logic [sfd_pkg::CH_W-1:0]        rsp_channel,
   output logic [sfd_pkg::IDX_W-1:0]       rsp_digit_index,
   output logic [sfd_pkg::NIB_W-1:0]       rsp_digit_value,
   output logic                            rsp_last,
   input  logic                            csr_wr_en,
   input  logic [sfd_pkg::PERIOD_W-1:0]    csr_wr_data
);
   import sfd_pkg::*;

   logic       front_push;
   job_type    front_job;
   logic       fifo_full;
   logic       fifo_empty;
   logic       back_pop;
   job_type    fifo_job;
   result_type result;

   sfd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_rx_byte (req_rx_byte),
      .job_push    (front_push),
      .job_data    (front_job),
      .job_full    (fifo_full)
   );

   sfd_job_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_job),
      .full      (fifo_full),
      .pop       (back_pop),
      .pop_data  (fifo_job),
      .empty     (fifo_empty)
   );

   sfd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .job_data    (fifo_job),
      .job_empty   (fifo_empty),
      .job_pop     (back_pop),
      .rsp_data    (result),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop)
   );

   assign rsp_kind        = result.kind;
   assign rsp_channel     = result.channel;
   assign rsp_digit_index = result.digit_index;
   assign rsp_digit_value = result.digit_value;
   assign rsp_last        = result.last;

endmodule
